>>> rtl/gct_pkg.sv
`timescale 1ns / 1ps

package gct_pkg;

	// request transaction
	typedef struct packed {
		logic        cmd;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [25:0] second_us;
		logic [12:0] week;
		logic [39:0] sow_us;
	} req_t;

	// response transaction
	typedef struct packed {
		logic [11:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [25:0] out_second_us;
		logic [12:0] out_week;
		logic [39:0] out_sow_us;
	} rsp_t;

	localparam int unsigned LAT = 7;

	localparam logic [36:0] US_PER_DAY  = 37'd86400000000;
	localparam logic [31:0] US_PER_HOUR = 32'd3600000000;
	localparam logic [25:0] US_PER_MIN  = 26'd60000000;

	// floor(30.6001 * idx)
	function automatic logic [9:0] month_base(input logic [4:0] idx);
		logic [9:0] v;
		case (idx)
			5'd0:    v = 10'd0;
			5'd1:    v = 10'd30;
			5'd2:    v = 10'd61;
			5'd3:    v = 10'd91;
			5'd4:    v = 10'd122;
			5'd5:    v = 10'd153;
			5'd6:    v = 10'd183;
			5'd7:    v = 10'd214;
			5'd8:    v = 10'd244;
			5'd9:    v = 10'd275;
			5'd10:   v = 10'd306;
			5'd11:   v = 10'd336;
			5'd12:   v = 10'd367;
			5'd13:   v = 10'd397;
			5'd14:   v = 10'd428;
			5'd15:   v = 10'd459;
			5'd16:   v = 10'd489;
			5'd17:   v = 10'd520;
			5'd18:   v = 10'd550;
			5'd19:   v = 10'd581;
			5'd20:   v = 10'd612;
			5'd21:   v = 10'd642;
			5'd22:   v = 10'd673;
			5'd23:   v = 10'd703;
			5'd24:   v = 10'd734;
			5'd25:   v = 10'd765;
			5'd26:   v = 10'd795;
			5'd27:   v = 10'd826;
			5'd28:   v = 10'd856;
			5'd29:   v = 10'd887;
			5'd30:   v = 10'd918;
			default: v = 10'd948;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/gct_cal2gps.sv
`timescale 1ns / 1ps

module gct_cal2gps (
	input  logic        clk,
	input  logic        en,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [25:0] second_us,
	output logic [12:0] week,
	output logic [39:0] sow_us
);

	localparam logic [21:0] MJD_BIAS = 22'd723263;
	localparam logic [21:0] RECIP7   = 22'((64'd1 << 24) / 7);

	// stage 1: day number since epoch and time of day
	logic               low_month;
	logic signed [21:0] year_adj;
	logic [4:0]         month_idx;
	logic signed [21:0] day_num;
	logic [36:0]        tod;

	assign low_month = month <= 4'd2;
	assign year_adj  = $signed({10'd0, year}) - (low_month ? 22'sd1 : 22'sd0);
	assign month_idx = low_month ? ({1'b0, month} + 5'd13) : ({1'b0, month} + 5'd1);
	assign day_num   = year_adj * 22'sd365 + (year_adj >>> 2)
		+ $signed({12'd0, gct_pkg::month_base(month_idx)})
		+ $signed({17'd0, day}) - $signed(MJD_BIAS);
	assign tod = 37'(hour) * 37'(gct_pkg::US_PER_HOUR)
		+ 37'(minute) * 37'(gct_pkg::US_PER_MIN) + 37'(second_us);

	logic signed [21:0] day_s1;
	logic [36:0]        tod_s1;

	// stage 2: carry whole days out of time of day, clamp before epoch
	logic               tod_carry;
	logic [36:0]        tod_norm;
	logic signed [21:0] day_norm;

	assign tod_carry = tod_s1 >= gct_pkg::US_PER_DAY;
	assign tod_norm  = tod_carry ? tod_s1 - gct_pkg::US_PER_DAY : tod_s1;
	assign day_norm  = day_s1 + (tod_carry ? 22'sd1 : 22'sd0);

	logic [19:0] day_s2;
	logic [36:0] tod_s2;

	// stage 3: week estimate by reciprocal
	logic [41:0] wk_prod;
	assign wk_prod = 42'(day_s2) * 42'(RECIP7);

	logic [16:0] wq_s3;
	logic [19:0] day_s3;
	logic [36:0] tod_s3;

	// stage 4: correct week, day of week into seconds of week
	logic [19:0] wk_rem;
	logic        wk_fix;
	logic [3:0]  dow;
	logic [16:0] wk_full;
	logic [39:0] sow_full;

	assign wk_rem   = day_s3 - 20'(wq_s3) * 20'd7;
	assign wk_fix   = wk_rem[3:0] >= 4'd7;
	assign dow      = wk_fix ? wk_rem[3:0] - 4'd7 : wk_rem[3:0];
	assign wk_full  = wq_s3 + 17'(wk_fix);
	assign sow_full = 40'(dow) * 40'(gct_pkg::US_PER_DAY) + 40'(tod_s3);

	logic [12:0] week_s [4:gct_pkg::LAT];
	logic [39:0] sow_s  [4:gct_pkg::LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			day_s1 <= day_num;
			tod_s1 <= tod;
			day_s2 <= day_norm[21] ? '0 : day_norm[19:0];
			tod_s2 <= day_norm[21] ? '0 : tod_norm;
			wq_s3  <= wk_prod[40:24];
			day_s3 <= day_s2;
			tod_s3 <= tod_s2;
			week_s[4] <= wk_full[12:0];
			sow_s[4]  <= sow_full;
			for (int k = 5; k <= gct_pkg::LAT; k++) begin
				week_s[k] <= week_s[k-1];
				sow_s[k]  <= sow_s[k-1];
			end
		end
	end

	assign week   = week_s[gct_pkg::LAT];
	assign sow_us = sow_s[gct_pkg::LAT];

endmodule

>>> rtl/gct_gps2cal.sv
`timescale 1ns / 1ps

module gct_gps2cal (
	input  logic        clk,
	input  logic        en,
	input  logic [12:0] week,
	input  logic [39:0] sow_us,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [25:0] second_us
);

	localparam logic [24:0] RECIP_C = 25'((64'd1 << 40) / 36525);
	localparam logic [18:0] RECIP_H = 19'((64'd1 << 40) / 3515625);
	localparam logic [22:0] RECIP_M = 23'((64'd1 << 40) / 234375);
	localparam logic [27:0] RECIP_E = 28'(((64'd1 << 32) * 10000) / 306001);

	// stage 1: whole days inside seconds of week
	logic [3:0]  day_cnt;
	logic [15:0] days;

	always_comb begin
		day_cnt = '0;
		for (int j = 1; j <= 12; j++) begin
			if (sow_us >= 40'(j) * 40'(gct_pkg::US_PER_DAY))
				day_cnt = day_cnt + 4'd1;
		end
	end
	assign days = 16'(week) * 16'd7 + 16'(day_cnt);

	logic [15:0] days_s1;
	logic [39:0] sow_s1;
	logic [3:0]  dcnt_s1;

	// stage 2: julian day terms and seconds of day
	logic [27:0] num_s2;
	logic [21:0] b_s2;
	logic [36:0] sod_s2;

	// stage 3: century-year and hour estimates
	logic [52:0] c_prod;
	logic [45:0] h_prod;
	assign c_prod = 53'(num_s2) * 53'(RECIP_C);
	assign h_prod = 46'(sod_s2[36:10]) * 46'(RECIP_H);

	logic [12:0] c_s3;
	logic [4:0]  hr_s3;
	logic [27:0] num_s3;
	logic [21:0] b_s3;
	logic [36:0] sod_s3;

	// stage 4: corrections
	logic [27:0] c_rem;
	logic [36:0] hr_rem;
	logic        hr_fix;
	assign c_rem  = num_s3 - 28'(c_s3) * 28'd36525;
	assign hr_rem = sod_s3 - 37'(hr_s3) * 37'(gct_pkg::US_PER_HOUR);
	assign hr_fix = hr_rem >= 37'(gct_pkg::US_PER_HOUR);

	logic [12:0] c_s4;
	logic [4:0]  hr_s4;
	logic [31:0] rem_s4;
	logic [21:0] b_s4;

	// stage 5: day of year term and minute estimate
	logic [21:0] doy;
	logic [46:0] m_prod;
	assign doy    = b_s4 - 22'(c_s4) * 22'd365 - 22'(c_s4 >> 2);
	assign m_prod = 47'(rem_s4[31:8]) * 47'(RECIP_M);

	logic [9:0]  doy_s5;
	logic [12:0] c_s5;
	logic [4:0]  hr_s5;
	logic [31:0] rem_s5;
	logic [5:0]  min_s5;

	// stage 6: month index estimate, minute correction
	logic [37:0] e_prod;
	logic [31:0] m_rem;
	logic        m_fix;
	assign e_prod = 38'(doy_s5) * 38'(RECIP_E);
	assign m_rem  = rem_s5 - 32'(min_s5) * 32'(gct_pkg::US_PER_MIN);
	assign m_fix  = m_rem >= 32'(gct_pkg::US_PER_MIN);

	logic [4:0]  e_s6;
	logic [9:0]  doy_s6;
	logic [12:0] c_s6;
	logic [4:0]  hr_s6;
	logic [5:0]  min_s6;
	logic [25:0] sec_s6;

	// stage 7: month, day and year
	logic [23:0] e_rem;
	logic [4:0]  e_fin;
	logic [9:0]  day_full;
	logic [4:0]  mon_full;
	logic [12:0] yr_full;
	assign e_rem    = 24'(doy_s6) * 24'd10000 - 24'(e_s6) * 24'd306001;
	assign e_fin    = e_s6 + 5'(e_rem >= 24'd306001);
	assign day_full = doy_s6 - gct_pkg::month_base(e_fin);
	assign mon_full = (e_fin >= 5'd14) ? e_fin - 5'd13 : e_fin - 5'd1;
	assign yr_full  = 13'(c_s6) - 13'd4715 - 13'(mon_full >= 5'd3);

	logic [11:0] year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  day_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  minute_s7;
	logic [25:0] sec_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			days_s1 <= days;
			sow_s1  <= sow_us;
			dcnt_s1 <= day_cnt;

			num_s2 <= 28'(days_s1) * 28'd100 + 28'd244565990;
			b_s2   <= 22'(days_s1) + 22'd2445782;
			sod_s2 <= 37'(sow_s1 - 40'(dcnt_s1) * 40'(gct_pkg::US_PER_DAY));

			c_s3   <= c_prod[52:40];
			hr_s3  <= h_prod[44:40];
			num_s3 <= num_s2;
			b_s3   <= b_s2;
			sod_s3 <= sod_s2;

			c_s4   <= c_s3 + 13'(c_rem >= 28'd36525);
			hr_s4  <= hr_s3 + 5'(hr_fix);
			rem_s4 <= hr_fix ? 32'(hr_rem - 37'(gct_pkg::US_PER_HOUR)) : 32'(hr_rem);
			b_s4   <= b_s3;

			doy_s5 <= doy[9:0];
			c_s5   <= c_s4;
			hr_s5  <= hr_s4;
			rem_s5 <= rem_s4;
			min_s5 <= m_prod[45:40];

			e_s6   <= e_prod[36:32];
			doy_s6 <= doy_s5;
			c_s6   <= c_s5;
			hr_s6  <= hr_s5;
			min_s6 <= min_s5 + 6'(m_fix);
			sec_s6 <= m_fix ? 26'(m_rem - 32'(gct_pkg::US_PER_MIN)) : 26'(m_rem);

			year_s7   <= yr_full[11:0];
			month_s7  <= mon_full[3:0];
			day_s7    <= day_full[4:0];
			hour_s7   <= hr_s6;
			minute_s7 <= min_s6;
			sec_s7    <= sec_s6;
		end
	end

	assign year      = year_s7;
	assign month     = month_s7;
	assign day       = day_s7;
	assign hour      = hour_s7;
	assign minute    = minute_s7;
	assign second_us = sec_s7;

endmodule

>>> rtl/gct_skid.sv
`timescale 1ns / 1ps

module gct_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  gct_pkg::rsp_t  up,
	output logic           dn_valid,
	input  logic           dn_ready,
	output gct_pkg::rsp_t  dn
);

	logic          out_vld_q;
	logic          spare_vld_q;
	gct_pkg::rsp_t out_q;
	gct_pkg::rsp_t spare_q;
	logic          take;

	assign up_ready = !spare_vld_q;
	assign take     = up_valid && !spare_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			spare_vld_q <= 1'b0;
		end else if (out_vld_q && !dn_ready) begin
			if (take)
				spare_vld_q <= 1'b1;
		end else if (spare_vld_q) begin
			out_vld_q   <= 1'b1;
			spare_vld_q <= 1'b0;
		end else begin
			out_vld_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !dn_ready) begin
			if (take)
				spare_q <= up;
		end else if (spare_vld_q) begin
			out_q <= spare_q;
		end else if (take) begin
			out_q <= up;
		end
	end

	assign dn_valid = out_vld_q;
	assign dn       = out_q;

endmodule

>>> rtl/gps_calendar_time_converter.sv
`timescale 1ns / 1ps

// calendar date and time <-> gps week and seconds of week, one conversion per transaction
// req channel: req_valid / req_ready / req, req.cmd 0 converts calendar to gps,
//   req.cmd 1 converts gps week plus seconds of week to calendar
// rsp channel: rsp_valid / rsp_ready / rsp, fields of the unused direction read as zero
// throughput: one transaction per cycle, sustained while rsp_ready stays high, for any mix of cmd values
// path from req acceptance to rsp_valid: the seven-stage datapath (reciprocal
//   multiply then correct for the constant divides, a compare chain for the whole
//   days in seconds of week) plus the output register
// calendar instants before the gps epoch give week 0 and seconds 0
// the week number wraps modulo 8192
// reset (arst_n low) empties the pipeline and the output buffer at once
// receiver stall: the output buffer holds one waiting result and one spare, so a
//   transaction is still taken in the cycle the stall begins; req_ready falls
//   only once the spare is filled, and the whole pipeline then holds in place
module gps_calendar_time_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gct_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output gct_pkg::rsp_t rsp
);

	localparam int unsigned LAT = gct_pkg::LAT;

	// pipeline advance, held while the output spare is occupied
	logic en;

	// valid and direction travelling beside the datapath
	logic [LAT:1] vld_s;
	logic [LAT:1] cmd_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], req_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			cmd_s <= {cmd_s[LAT-1:1], req.cmd};
	end

	// both directions run on every transaction, cmd picks the result
	logic [12:0] g_week;
	logic [39:0] g_sow;
	logic [11:0] c_year;
	logic [3:0]  c_month;
	logic [4:0]  c_day;
	logic [4:0]  c_hour;
	logic [5:0]  c_minute;
	logic [25:0] c_second;

	gct_cal2gps u_cal2gps (
		.clk       (clk),
		.en        (en),
		.year      (req.year),
		.month     (req.month),
		.day       (req.day),
		.hour      (req.hour),
		.minute    (req.minute),
		.second_us (req.second_us),
		.week      (g_week),
		.sow_us    (g_sow)
	);

	gct_gps2cal u_gps2cal (
		.clk       (clk),
		.en        (en),
		.week      (req.week),
		.sow_us    (req.sow_us),
		.year      (c_year),
		.month     (c_month),
		.day       (c_day),
		.hour      (c_hour),
		.minute    (c_minute),
		.second_us (c_second)
	);

	gct_pkg::rsp_t result;

	always_comb begin
		result = '0;
		if (cmd_s[LAT]) begin
			result.out_year      = c_year;
			result.out_month     = c_month;
			result.out_day       = c_day;
			result.out_hour      = c_hour;
			result.out_minute    = c_minute;
			result.out_second_us = c_second;
		end else begin
			result.out_week   = g_week;
			result.out_sow_us = g_sow;
		end
	end

	// output register with spare entry
	gct_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld_s[LAT]),
		.up_ready (en),
		.up       (result),
		.dn_valid (rsp_valid),
		.dn_ready (rsp_ready),
		.dn       (rsp)
	);

	assign req_ready = en;

	// spare only fills behind a stalled result
	a_spare_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("output spare occupied with no result shown");

	// a finished transaction is not dropped while the pipeline holds
	a_tail_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAT] && !en) |=> vld_s[LAT])
		else $error("pipeline tail lost during hold");

	// only one direction's fields carry data
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.out_week == 13'd0 && rsp.out_sow_us == 40'd0) ||
			(rsp.out_year == 12'd0 && rsp.out_month == 4'd0 && rsp.out_day == 5'd0 &&
			rsp.out_hour == 5'd0 && rsp.out_minute == 6'd0 && rsp.out_second_us == 26'd0)))
		else $error("response mixes both directions");

endmodule
